/* rtl/stlfo_pkg.sv */
// Shared constants, types and the sine quarter-table function for the stereo tremolo LFO.
`default_nettype none

package stlfo_pkg;

  localparam int SampleWidthDef = 24;
  localparam int SineDepthDef   = 1024;
  localparam int PhaseWidthDef  = 32;

  // configuration port
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 31;
  localparam logic [CfgIdxW-1:0] RegGainLevel = 2'd0;
  localparam logic [CfgIdxW-1:0] RegModDepth  = 2'd1;
  localparam logic [CfgIdxW-1:0] RegPhaseStep = 2'd2;

  localparam logic [15:0] GainLevelRst = 16'd16384;
  localparam logic [15:0] ModDepthRst  = 16'd16384;
  localparam logic [30:0] PhaseStepRst = 31'd178957;
  localparam logic [15:0] Unity        = 16'd32768;

  localparam logic [63:0] HalfPiQ30 = 64'd1686629713;
  localparam logic [63:0] Q30One    = 64'd1073741824;

  // shared multiplier operand select
  localparam logic [1:0] MulNone   = 2'd0;
  localparam logic [1:0] MulDepth  = 2'd1;
  localparam logic [1:0] MulLevel  = 2'd2;
  localparam logic [1:0] MulSample = 2'd3;

  typedef struct packed {
    logic       load;       // capture input word
    logic       idx_en;     // compute table index from phase
    logic       sine_en;    // look up sine, advance phase
    logic [1:0] mul_op;     // shared multiplier operands
    logic       ch;         // 0 left, 1 right
    logic       keep_left;  // hold left result
    logic       out_load;   // load output register
  } stlfo_cmd_t;

  // Q30 Taylor/Horner sine of angle x, rounded to unsigned Q0.15 and clipped.
  function automatic logic [14:0] sine_entry(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] v;
    x2 = (x * x) >> 30;
    t  = Q30One;
    t  = Q30One - (((x2 * t) >> 30) / 64'd156);
    t  = Q30One - (((x2 * t) >> 30) / 64'd110);
    t  = Q30One - (((x2 * t) >> 30) / 64'd72);
    t  = Q30One - (((x2 * t) >> 30) / 64'd42);
    t  = Q30One - (((x2 * t) >> 30) / 64'd20);
    t  = Q30One - (((x2 * t) >> 30) / 64'd6);
    v  = (x * t) >> 30;
    v  = (v + 64'd16384) >> 15;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return v[14:0];
  endfunction

endpackage

`default_nettype wire

/* rtl/stlfo_ctrl.sv */
// Sequencer for the tremolo: steps one frame through index, lookup and the shared multiplier.
`default_nettype none

module stlfo_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  output stlfo_pkg::stlfo_cmd_t     cmd_o
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StIdx  = 3'd1;
  localparam logic [2:0] StSine = 3'd2;
  localparam logic [2:0] StM1   = 3'd3;
  localparam logic [2:0] StM2   = 3'd4;
  localparam logic [2:0] StM3   = 3'd5;
  localparam logic [2:0] StM4   = 3'd6;

  logic [2:0] state_q, state_d;
  logic       ch_q, ch_d;
  logic       ovalid_q, ovalid_d;
  stlfo_pkg::stlfo_cmd_t cmd;

  always_comb begin
    state_d      = state_q;
    ch_d         = ch_q;
    cmd          = '0;
    cmd.mul_op   = stlfo_pkg::MulNone;
    cmd.ch       = ch_q;
    case (state_q)
      StIdle: begin
        if (s_axis_tvalid) begin
          cmd.load = 1'b1;
          state_d  = StIdx;
        end
      end
      StIdx: begin
        cmd.idx_en = 1'b1;
        state_d    = StSine;
      end
      StSine: begin
        cmd.sine_en = 1'b1;
        ch_d        = 1'b0;
        state_d     = StM1;
      end
      StM1: begin
        cmd.mul_op = stlfo_pkg::MulDepth;
        state_d    = StM2;
      end
      StM2: begin
        cmd.mul_op = stlfo_pkg::MulLevel;
        state_d    = StM3;
      end
      StM3: begin
        cmd.mul_op = stlfo_pkg::MulSample;
        state_d    = StM4;
      end
      StM4: begin
        if (!ch_q) begin
          cmd.keep_left = 1'b1;
          ch_d          = 1'b1;
          state_d       = StM1;
        end else if (!ovalid_q || m_axis_tready) begin
          // hold here while the previous word still waits
          cmd.out_load = 1'b1;
          state_d      = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_comb begin
    ovalid_d = ovalid_q;
    if (cmd.out_load) begin
      ovalid_d = 1'b1;
    end else if (m_axis_tready) begin
      ovalid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      ch_q     <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ch_q     <= ch_d;
      ovalid_q <= ovalid_d;
    end
  end

  assign s_axis_tready = (state_q == StIdle);
  assign m_axis_tvalid = ovalid_q;
  assign cmd_o         = cmd;

endmodule

`default_nettype wire

/* rtl/stlfo_dpath.sv */
// Datapath: config registers, phase accumulator, sine table and one shared multiplier.
`default_nettype none

module stlfo_dpath #(
  parameter int SampleWidth = stlfo_pkg::SampleWidthDef,
  parameter int SineDepth   = stlfo_pkg::SineDepthDef,
  parameter int PhaseWidth  = stlfo_pkg::PhaseWidthDef,
  localparam int TdataW     = ((2 * SampleWidth + 7) / 8) * 8
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_we_i,
  input  wire logic [stlfo_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  wire logic [stlfo_pkg::CfgDataW-1:0]       cfg_data_i,
  input  wire logic [TdataW-1:0]                    s_axis_tdata,
  output logic [TdataW-1:0]                         m_axis_tdata,
  input  wire stlfo_pkg::stlfo_cmd_t                cmd_i
);

  localparam int Quarter = SineDepth / 4;
  localparam int IdxW    = $clog2(SineDepth);
  localparam int RomW    = $clog2(Quarter + 1);
  localparam int AW      = ((SampleWidth > 16) ? SampleWidth : 16) + 1;
  localparam int PW      = AW + 17;
  localparam int SW      = SampleWidth;

  // quarter-wave table, evaluated at elaboration
  logic [14:0] sine_rom [0:Quarter];
  for (genvar g = 0; g <= Quarter; g++) begin : g_rom
    assign sine_rom[g] = stlfo_pkg::sine_entry((stlfo_pkg::HalfPiQ30 * 64'(g)) / Quarter);
  end

  // configuration
  logic [15:0] level_q;
  logic [15:0] depth_q;
  logic [30:0] step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= stlfo_pkg::GainLevelRst;
      depth_q <= stlfo_pkg::ModDepthRst;
      step_q  <= stlfo_pkg::PhaseStepRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        stlfo_pkg::RegGainLevel: level_q <= cfg_data_i[15:0];
        stlfo_pkg::RegModDepth:  depth_q <= cfg_data_i[15:0];
        stlfo_pkg::RegPhaseStep: step_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [15:0] level_sat;
  logic [15:0] depth_sat;
  assign level_sat = (level_q > stlfo_pkg::Unity) ? stlfo_pkg::Unity : level_q;
  assign depth_sat = (depth_q > stlfo_pkg::Unity) ? stlfo_pkg::Unity : depth_q;

  // phase accumulator
  logic [PhaseWidth-1:0]    phase_q;
  logic [PhaseWidth+30:0]   phase_sum;
  assign phase_sum = (PhaseWidth + 31)'(phase_q) + (PhaseWidth + 31)'(step_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
    end else if (cmd_i.sine_en) begin
      phase_q <= phase_sum[PhaseWidth-1:0];
    end
  end

  // input word
  logic signed [SW-1:0] left_q;
  logic signed [SW-1:0] right_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      left_q  <= s_axis_tdata[SW-1:0];
      right_q <= s_axis_tdata[2*SW-1:SW];
    end
  end

  // full-period table index
  logic [PhaseWidth+IdxW-1:0] idx_prod;
  logic [IdxW-1:0]            idx_q;
  assign idx_prod = (PhaseWidth + IdxW)'(phase_q) * (PhaseWidth + IdxW)'(SineDepth);
  always_ff @(posedge clk_i) begin
    if (cmd_i.idx_en) begin
      idx_q <= idx_prod[PhaseWidth+IdxW-1:PhaseWidth];
    end
  end

  // fold into the first quarter
  logic [IdxW:0]       iw;
  logic [RomW-1:0]     rom_addr;
  logic                neg;
  logic                zero;
  logic [14:0]         entry;
  logic signed [15:0]  sin_d;
  logic signed [15:0]  sin_q;

  always_comb begin
    iw       = {1'b0, idx_q};
    rom_addr = '0;
    neg      = 1'b0;
    zero     = 1'b0;
    if (iw < (IdxW + 1)'(Quarter)) begin
      rom_addr = RomW'(iw);
    end else if (iw < (IdxW + 1)'(2 * Quarter)) begin
      rom_addr = RomW'((IdxW + 1)'(2 * Quarter) - iw);
    end else if (iw < (IdxW + 1)'(3 * Quarter)) begin
      rom_addr = RomW'(iw - (IdxW + 1)'(2 * Quarter));
      neg      = 1'b1;
    end else if (iw < (IdxW + 1)'(4 * Quarter)) begin
      rom_addr = RomW'((IdxW + 1)'(4 * Quarter) - iw);
      neg      = 1'b1;
    end else begin
      zero = 1'b1;
    end
    entry = sine_rom[rom_addr];
    if (zero) begin
      sin_d = '0;
    end else if (neg) begin
      sin_d = -$signed({1'b0, entry});
    end else begin
      sin_d = $signed({1'b0, entry});
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sine_en) begin
      sin_q <= sin_d;
    end
  end

  // per-channel modulation: right channel takes the inverted LFO
  logic signed [17:0] m_sum;
  logic [14:0]        half;
  assign m_sum = cmd_i.ch ? (18'sd32768 - 18'(sin_q)) : (18'sd32768 + 18'(sin_q));
  assign half  = m_sum[15:1];

  logic signed [PW-1:0] prod_q;
  logic [16:0]          inner_sum;
  logic [15:0]          gain;
  assign inner_sum = 17'd32768 - {1'b0, depth_sat} + {2'b0, prod_q[29:15]};
  assign gain      = prod_q[30:15];

  logic signed [AW-1:0] mul_a;
  logic signed [16:0]   mul_b;
  logic signed [SW-1:0] sample;
  assign sample = cmd_i.ch ? right_q : left_q;

  always_comb begin
    case (cmd_i.mul_op)
      stlfo_pkg::MulDepth: begin
        mul_a = $signed({{(AW - 16){1'b0}}, depth_sat});
        mul_b = $signed({2'b00, half});
      end
      stlfo_pkg::MulLevel: begin
        mul_a = $signed({{(AW - 16){1'b0}}, level_sat});
        mul_b = $signed({1'b0, inner_sum[15:0]});
      end
      stlfo_pkg::MulSample: begin
        mul_a = $signed({{(AW - SW){sample[SW-1]}}, sample});
        mul_b = $signed({1'b0, gain});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_op != stlfo_pkg::MulNone) begin
      prod_q <= mul_a * mul_b;
    end
  end

  // floor shift by 15 is an arithmetic slice of the product
  logic signed [SW-1:0] scaled;
  logic signed [SW-1:0] left_res_q;
  logic signed [SW-1:0] out_left_q;
  logic signed [SW-1:0] out_right_q;
  assign scaled = prod_q[SW+14:15];

  always_ff @(posedge clk_i) begin
    if (cmd_i.keep_left) begin
      left_res_q <= scaled;
    end
    if (cmd_i.out_load) begin
      out_left_q  <= left_res_q;
      out_right_q <= scaled;
    end
  end

  assign m_axis_tdata = TdataW'({out_right_q, out_left_q});

endmodule

`default_nettype wire

/* rtl/stereo_tremolo_lfo_core.sv */
// Top level of the stereo sine-LFO tremolo: sequencer plus datapath.
//
//   port group    dir  contents (low bits first)
//   s_axis_*      in   tdata: left_in, right_in, zero pad to bytes
//   m_axis_*      out  tdata: left_out, right_out, zero pad to bytes
//   cfg_*         in   we, idx (0 gain_level, 1 mod_depth, 2 phase_step), data
//
// A frame goes from acceptance to a valid result; the input opens again in that
// same cycle, so a new frame is taken only after the last one is done.
// Three products per channel go through one shared multiplier, one step per
// cycle, plus a result step per channel after index and table lookup.
// A result waiting in the output register stalls the sequencer only
// at its last step. Reset clears the phase and loads the register defaults.
`default_nettype none

module stereo_tremolo_lfo_core #(
  parameter int SAMPLE_WIDTH     = stlfo_pkg::SampleWidthDef,
  parameter int SINE_TABLE_DEPTH = stlfo_pkg::SineDepthDef,
  parameter int PHASE_WIDTH      = stlfo_pkg::PhaseWidthDef,
  localparam int TdataW          = ((2 * SAMPLE_WIDTH + 7) / 8) * 8
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [stlfo_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  wire logic [stlfo_pkg::CfgDataW-1:0]   cfg_data_i,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  wire logic [TdataW-1:0]                s_axis_tdata,  // left_in, right_in
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  output logic [TdataW-1:0]                     m_axis_tdata   // left_out, right_out
);

  stlfo_pkg::stlfo_cmd_t cmd;

  stlfo_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cmd_o         (cmd)
  );

  stlfo_dpath #(
    .SampleWidth (SAMPLE_WIDTH),
    .SineDepth   (SINE_TABLE_DEPTH),
    .PhaseWidth  (PHASE_WIDTH)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tdata (m_axis_tdata),
    .cmd_i        (cmd)
  );

endmodule

`default_nettype wire

/* rtl/stlfo_checker.sv */
// Port-level checks for the tremolo core, bound to the top level.
`default_nettype none

module stlfo_checker #(
  parameter int TdataW = 48
) (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              s_axis_tvalid,
  input wire logic              s_axis_tready,
  input wire logic              m_axis_tvalid,
  input wire logic              m_axis_tready,
  input wire logic [TdataW-1:0] m_axis_tdata
);

  // a stalled word stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled output word changed or dropped");

  // an accepted frame does not let the input reopen early
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready ##1 !s_axis_tready)
    else $error("input reopened too early after a frame");

  // a new result only appears at the end of a busy frame
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result appeared without a frame in progress");

endmodule

bind stereo_tremolo_lfo_core stlfo_checker #(.TdataW(TdataW)) u_stlfo_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
